// ===== rtl/core/rcb_pkg.sv =====
`default_nettype none
package rcb_pkg;

  localparam int unsigned PIXEL_MAX_DEF = 255;
  localparam int unsigned CH_W          = 8;
  localparam int unsigned SHIFT_W       = 8;
  localparam int unsigned SHIFT_LIMIT   = 100;
  localparam int unsigned MAG_W         = 7;

  // curve gain is 0.667 percent-scaled: 667 / (1000 * 100)
  localparam longint unsigned CURVE_GAIN  = 667;
  localparam longint unsigned CURVE_SCALE = 100000;
  // largest code an 8-bit channel can carry
  localparam longint unsigned IN_SPAN     = 255;

  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;

  localparam logic [1:0] REG_RED   = 2'd0;
  localparam logic [1:0] REG_GREEN = 2'd1;
  localparam logic [1:0] REG_BLUE  = 2'd2;

  localparam logic signed [SHIFT_W-1:0] SHIFT_HI = SHIFT_W'(SHIFT_LIMIT);
  localparam logic signed [SHIFT_W-1:0] SHIFT_LO = -SHIFT_HI;

  typedef struct packed {
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
  } pix_out_t;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } shift_t;

  // clip the percent setting to +/-100 and split into sign and magnitude
  function automatic shift_t sat_shift(input logic signed [SHIFT_W-1:0] s);
    shift_t                      r;
    logic signed [SHIFT_W-1:0]   c;
    if (s > SHIFT_HI) begin
      c = SHIFT_HI;
    end else if (s < SHIFT_LO) begin
      c = SHIFT_LO;
    end else begin
      c = s;
    end
    r.neg = c[SHIFT_W-1];
    r.mag = c[SHIFT_W-1] ? MAG_W'(-c) : MAG_W'(c);
    return r;
  endfunction

  function automatic longint unsigned half_of(input longint unsigned pmax);
    return pmax >> 1;
  endfunction

  // signed width of v - H for any 8-bit v
  function automatic int unsigned diff_w(input longint unsigned pmax);
    longint unsigned h;
    h = half_of(pmax);
    return $clog2(((h > IN_SPAN) ? h : IN_SPAN) + 1) + 1;
  endfunction

  // bound on |H*H - (v-H)^2|
  function automatic longint unsigned curve_max(input longint unsigned pmax);
    longint unsigned h;
    h = half_of(pmax);
    return ((h * h) > (IN_SPAN * IN_SPAN)) ? (h * h) : (IN_SPAN * IN_SPAN);
  endfunction

  function automatic longint unsigned gain_k(input longint unsigned pmax);
    return pmax * CURVE_GAIN;
  endfunction

  function automatic longint unsigned num_max(input longint unsigned pmax);
    return SHIFT_LIMIT * gain_k(pmax) * curve_max(pmax);
  endfunction

  function automatic longint unsigned den_of(input longint unsigned pmax);
    longint unsigned h;
    h = half_of(pmax);
    return CURVE_SCALE * h * h;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rcb_front.sv =====
`default_nettype none
module rcb_front #(
  parameter int unsigned PIXEL_MAX = rcb_pkg::PIXEL_MAX_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic [rcb_pkg::CH_W-1:0]          v_i,
  input  wire logic signed [rcb_pkg::SHIFT_W-1:0] shift_i,
  output logic [$clog2(rcb_pkg::num_max(PIXEL_MAX) + 1)-1:0] n_o,
  output logic                                   neg_o,
  output logic [rcb_pkg::CH_W-1:0]               v_o
);

  localparam longint unsigned H   = rcb_pkg::half_of(PIXEL_MAX);
  localparam longint unsigned H2  = H * H;
  localparam int unsigned     DW  = rcb_pkg::diff_w(PIXEL_MAX);
  localparam int unsigned     CW  = 2 * DW - 2;
  localparam longint unsigned K   = rcb_pkg::gain_k(PIXEL_MAX);
  localparam int unsigned     AKW = $clog2(rcb_pkg::SHIFT_LIMIT * K + 1);
  localparam int unsigned     NW  = $clog2(rcb_pkg::num_max(PIXEL_MAX) + 1);

  // stage A: curve and gain, two multipliers side by side
  logic signed [DW-1:0]   diff;
  logic [2*DW-1:0]        sq;
  logic signed [CW:0]     curve_d;
  logic signed [CW:0]     curve_q;
  rcb_pkg::shift_t        sh;
  logic [AKW-1:0]         ak_d;
  logic [AKW-1:0]         ak_q;
  logic                   aneg_q;
  logic [rcb_pkg::CH_W-1:0] v_a_q;

  assign diff    = $signed(DW'(v_i)) - $signed(DW'(H));
  assign sq      = (2*DW)'(diff) * (2*DW)'(diff);
  assign curve_d = $signed((CW+1)'(H2)) - $signed((CW+1)'(sq));
  assign sh      = rcb_pkg::sat_shift(shift_i);
  assign ak_d    = AKW'(sh.mag * K);

  always_ff @(posedge clk_i) begin
    curve_q <= curve_d;
    ak_q    <= ak_d;
    aneg_q  <= sh.neg;
    v_a_q   <= v_i;
  end

  // stage B: numerator magnitude, sign kept apart
  logic [CW-1:0]     cmag;
  logic [AKW+CW-1:0] prod;
  logic [NW-1:0]     n_q;
  logic              neg_q;
  logic [rcb_pkg::CH_W-1:0] v_b_q;

  assign cmag = curve_q[CW] ? CW'(-curve_q) : CW'(curve_q);
  assign prod = ak_q * cmag;

  always_ff @(posedge clk_i) begin
    n_q   <= prod[NW-1:0];
    neg_q <= aneg_q ^ curve_q[CW];
    v_b_q <= v_a_q;
  end

  assign n_o   = n_q;
  assign neg_o = neg_q;
  assign v_o   = v_b_q;

endmodule
`default_nettype wire

// ===== rtl/core/rcb_divider.sv =====
`default_nettype none
module rcb_divider #(
  parameter int unsigned PIXEL_MAX = rcb_pkg::PIXEL_MAX_DEF
) (
  input  wire logic                                          clk_i,
  input  wire logic [$clog2(rcb_pkg::num_max(PIXEL_MAX) + 1)-1:0] n_i,
  input  wire logic                                          neg_i,
  input  wire logic [rcb_pkg::CH_W-1:0]                      v_i,
  output logic [(((rcb_pkg::num_max(PIXEL_MAX) / rcb_pkg::den_of(PIXEL_MAX)) > 0) ?
                 $clog2((rcb_pkg::num_max(PIXEL_MAX) / rcb_pkg::den_of(PIXEL_MAX)) + 1)
                 : 1)-1:0]                                   q_o,
  output logic                                               neg_o,
  output logic [rcb_pkg::CH_W-1:0]                           v_o
);

  localparam longint unsigned DEN  = rcb_pkg::den_of(PIXEL_MAX);
  localparam longint unsigned NMAX = rcb_pkg::num_max(PIXEL_MAX);
  localparam int unsigned     NW   = $clog2(NMAX + 1);
  localparam longint unsigned QMAX = NMAX / DEN;
  localparam int unsigned     QW   = (QMAX > 0) ? $clog2(QMAX + 1) : 1;
  // numerator bits below the largest power of two not above the divisor are dropped
  localparam int unsigned     TS   = $clog2(DEN + 1) - 1;
  localparam int unsigned     HW   = NW - TS;
  localparam longint unsigned RCP  = (64'd1 << NW) / DEN;
  localparam int unsigned     RW   = $clog2(RCP + 1);

  // stage 1: quotient estimate from the top numerator bits, never above the true quotient
  logic [HW-1:0]            n_hi;
  logic [HW+RW-1:0]         est_prod;
  logic [QW-1:0]            est_q;
  logic [NW-1:0]            n_q;
  logic                     neg1_q;
  logic [rcb_pkg::CH_W-1:0] v1_q;

  assign n_hi     = n_i[NW-1:TS];
  assign est_prod = (HW+RW)'(n_hi) * (HW+RW)'(RCP);

  always_ff @(posedge clk_i) begin
    est_q  <= QW'(est_prod >> HW);
    n_q    <= n_i;
    neg1_q <= neg_i;
    v1_q   <= v_i;
  end

  // stage 2: remainder left by the estimate, below three divisors
  logic [NW-1:0]            rem_d;
  logic [NW-1:0]            rem_q;
  logic [QW-1:0]            est2_q;
  logic                     neg2_q;
  logic [rcb_pkg::CH_W-1:0] v2_q;

  assign rem_d = n_q - NW'(est_q * DEN);

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    est2_q <= est_q;
    neg2_q <= neg1_q;
    v2_q   <= v1_q;
  end

  // stage 3: up to two divisors of correction, compared side by side
  logic [QW-1:0]            quo_d;
  logic [QW-1:0]            quo_q;
  logic                     neg3_q;
  logic [rcb_pkg::CH_W-1:0] v3_q;

  always_comb begin
    if (64'(rem_q) >= 2 * DEN) begin
      quo_d = est2_q + QW'(2);
    end else if (64'(rem_q) >= DEN) begin
      quo_d = est2_q + QW'(1);
    end else begin
      quo_d = est2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    neg3_q <= neg2_q;
    v3_q   <= v2_q;
  end

  assign q_o   = quo_q;
  assign neg_o = neg3_q;
  assign v_o   = v3_q;

endmodule
`default_nettype wire

// ===== rtl/core/rcb_clamp.sv =====
`default_nettype none
module rcb_clamp #(
  parameter int unsigned PIXEL_MAX = rcb_pkg::PIXEL_MAX_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic [(((rcb_pkg::num_max(PIXEL_MAX) / rcb_pkg::den_of(PIXEL_MAX)) > 0) ?
                      $clog2((rcb_pkg::num_max(PIXEL_MAX) / rcb_pkg::den_of(PIXEL_MAX)) + 1)
                      : 1)-1:0]         q_i,
  input  wire logic                     neg_i,
  input  wire logic [rcb_pkg::CH_W-1:0] v_i,
  output logic [rcb_pkg::CH_W-1:0]      ch_o
);

  localparam longint unsigned QMAX = rcb_pkg::num_max(PIXEL_MAX) / rcb_pkg::den_of(PIXEL_MAX);
  localparam int unsigned     QW   = (QMAX > 0) ? $clog2(QMAX + 1) : 1;
  localparam int unsigned     SW   = ((QW > rcb_pkg::CH_W) ? QW : rcb_pkg::CH_W) + 1;

  logic [SW-1:0]            vx;
  logic [SW-1:0]            qx;
  logic [SW-1:0]            lim;
  logic [rcb_pkg::CH_W-1:0] res;
  logic [rcb_pkg::CH_W-1:0] ch_q;

  always_comb begin
    vx = SW'(v_i);
    qx = SW'(q_i);
    if (neg_i) begin
      lim = (qx > vx) ? '0 : (vx - qx);
    end else begin
      lim = vx + qx;
    end
    // clamp to the pixel range, then keep the low channel bits
    if (64'(lim) > 64'(PIXEL_MAX)) begin
      res = rcb_pkg::CH_W'(PIXEL_MAX);
    end else begin
      res = lim[rcb_pkg::CH_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q <= res;
  end

  assign ch_o = ch_q;

endmodule
`default_nettype wire

// ===== rtl/core/rgb_color_balance.sv =====
`default_nettype none
// RGB color balance with a midtone curve. One pixel is taken on every clock
// (busy never rises) and its balanced result appears on result_o, marked by
// done_o, after the curve and gain multiply registers, the constant divider
// registers (reciprocal estimate, remainder, correction of up to two) and the
// add and clamp register. Each result beat is on the port for exactly one
// cycle and cannot be held off, so the receiver must take it then. The three
// signed percent shifts sit at byte addresses 0x0, 0x4 and 0x8 of the APB port;
// the user must write them while the pipe is empty; nothing here enforces it.
module rgb_color_balance #(
  parameter int unsigned PIXEL_MAX = rcb_pkg::PIXEL_MAX_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire rcb_pkg::pix_in_t            pixel_i,
  output logic                             done_o,
  output rcb_pkg::pix_out_t                result_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rcb_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [rcb_pkg::CFG_DW-1:0]  pwdata,
  output logic [rcb_pkg::CFG_DW-1:0]       prdata,
  output logic                             pready
);

  localparam longint unsigned NMAX    = rcb_pkg::num_max(PIXEL_MAX);
  localparam int unsigned     NW      = $clog2(NMAX + 1);
  localparam longint unsigned QMAX    = NMAX / rcb_pkg::den_of(PIXEL_MAX);
  localparam int unsigned     QW      = (QMAX > 0) ? $clog2(QMAX + 1) : 1;
  localparam int unsigned     LATENCY = 6;
  localparam int unsigned     NCH     = 3;
  localparam int unsigned     SX      = rcb_pkg::CFG_DW - rcb_pkg::SHIFT_W;

  // ---------------- configuration ----------------
  logic signed [rcb_pkg::SHIFT_W-1:0] red_shift_q;
  logic signed [rcb_pkg::SHIFT_W-1:0] green_shift_q;
  logic signed [rcb_pkg::SHIFT_W-1:0] blue_shift_q;
  logic                               wr_en;
  logic [1:0]                         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[rcb_pkg::CFG_AW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_shift_q   <= '0;
      green_shift_q <= '0;
      blue_shift_q  <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        rcb_pkg::REG_RED:   red_shift_q   <= pwdata[rcb_pkg::SHIFT_W-1:0];
        rcb_pkg::REG_GREEN: green_shift_q <= pwdata[rcb_pkg::SHIFT_W-1:0];
        rcb_pkg::REG_BLUE:  blue_shift_q  <= pwdata[rcb_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rcb_pkg::REG_RED:   prdata = {{SX{red_shift_q[rcb_pkg::SHIFT_W-1]}}, red_shift_q};
      rcb_pkg::REG_GREEN: prdata = {{SX{green_shift_q[rcb_pkg::SHIFT_W-1]}}, green_shift_q};
      rcb_pkg::REG_BLUE:  prdata = {{SX{blue_shift_q[rcb_pkg::SHIFT_W-1]}}, blue_shift_q};
      default:            prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic               accept;
  logic [LATENCY-1:0] vld_q;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LATENCY-2:0], accept};
    end
  end

  assign done_o = vld_q[LATENCY-1];

  // ---------------- datapath, one lane per channel ----------------
  logic [rcb_pkg::CH_W-1:0]           ch_in  [NCH];
  logic signed [rcb_pkg::SHIFT_W-1:0] ch_sh  [NCH];
  logic [rcb_pkg::CH_W-1:0]           ch_out [NCH];

  assign ch_in[0] = pixel_i.in_red;
  assign ch_in[1] = pixel_i.in_green;
  assign ch_in[2] = pixel_i.in_blue;
  assign ch_sh[0] = red_shift_q;
  assign ch_sh[1] = green_shift_q;
  assign ch_sh[2] = blue_shift_q;

  for (genvar c = 0; c < NCH; c++) begin : g_lane
    logic [NW-1:0]            n_b;
    logic                     neg_b;
    logic [rcb_pkg::CH_W-1:0] v_b;
    logic [QW-1:0]            q_c;
    logic                     neg_c;
    logic [rcb_pkg::CH_W-1:0] v_c;

    rcb_front #(.PIXEL_MAX(PIXEL_MAX)) u_front (
      .clk_i   (clk_i),
      .v_i     (ch_in[c]),
      .shift_i (ch_sh[c]),
      .n_o     (n_b),
      .neg_o   (neg_b),
      .v_o     (v_b)
    );

    rcb_divider #(.PIXEL_MAX(PIXEL_MAX)) u_div (
      .clk_i (clk_i),
      .n_i   (n_b),
      .neg_i (neg_b),
      .v_i   (v_b),
      .q_o   (q_c),
      .neg_o (neg_c),
      .v_o   (v_c)
    );

    rcb_clamp #(.PIXEL_MAX(PIXEL_MAX)) u_clamp (
      .clk_i (clk_i),
      .q_i   (q_c),
      .neg_i (neg_c),
      .v_i   (v_c),
      .ch_o  (ch_out[c])
    );
  end

  assign result_o.out_red   = ch_out[0];
  assign result_o.out_green = ch_out[1];
  assign result_o.out_blue  = ch_out[2];

endmodule
`default_nettype wire

// ===== rtl/core/rcb_checker.sv =====
`default_nettype none
module rcb_checker #(
  parameter int unsigned LATENCY   = 4,
  parameter int unsigned PIXEL_MAX = rcb_pkg::PIXEL_MAX_DEF
) (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic                       done_o,
  input wire rcb_pkg::pix_out_t          result_o,
  input wire logic                       psel,
  input wire logic                       penable,
  input wire logic                       pwrite,
  input wire logic [rcb_pkg::CFG_AW-1:0] paddr,
  input wire logic [rcb_pkg::CFG_DW-1:0] pwdata,
  input wire logic [rcb_pkg::CFG_DW-1:0] prdata
);

  // every accepted pixel comes out after the fixed pipe depth
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_o)
    else $error("accepted pixel not delivered after pipe latency");

  // no result beat without a matching accepted pixel
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("result beat without an accepted pixel");

  // results stay within the pixel range when it fits the channel width
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (PIXEL_MAX < 256)) |->
      (result_o.out_red <= PIXEL_MAX) && (result_o.out_green <= PIXEL_MAX) &&
      (result_o.out_blue <= PIXEL_MAX))
    else $error("result channel above pixel range");

  // a shift register reads back what was just written to it
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite &&
     (paddr[rcb_pkg::CFG_AW-1:2] <= rcb_pkg::REG_BLUE)) ##1
    (psel && !pwrite && (paddr == $past(paddr))) |->
      (prdata[rcb_pkg::SHIFT_W-1:0] == $past(pwdata[rcb_pkg::SHIFT_W-1:0])))
    else $error("shift register readback mismatch");

endmodule

bind rgb_color_balance rcb_checker #(
  .LATENCY   (LATENCY),
  .PIXEL_MAX (PIXEL_MAX)
) u_rcb_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .prdata   (prdata)
);
`default_nettype wire
